// File: rtl/joint_limit_velocity_guard_assert.svh
// ----------------------------------------------------------------------------
// joint limit velocity guard assertion macros
// concurrent checks sampled on clk, held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef JOINT_LIMIT_VELOCITY_GUARD_ASSERT_SVH
`define JOINT_LIMIT_VELOCITY_GUARD_ASSERT_SVH

`ifndef SYNTHESIS

`define JLVG_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("jlvg check failed");

`define JLVG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error("jlvg check failed");

`else

`define JLVG_ASSERT(label, prop)

`define JLVG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/jlvg_pkg.sv
// ----------------------------------------------------------------------------
// jlvg_pkg
// types, codes and reset values shared by the joint limit velocity guard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jlvg_pkg;

	localparam int VALUE_W   = 24;
	localparam int XW        = VALUE_W + 1;
	localparam int SPEED_W   = VALUE_W - 1;
	localparam int TICK_W    = 16;
	localparam int CFG_IDX_W = 3;

	localparam int RESULT_DEPTH = 4;
	localparam int RPTR_W       = $clog2(RESULT_DEPTH);
	localparam int RCNT_W       = $clog2(RESULT_DEPTH + 1);

	typedef logic [1:0]                 mode_t;
	typedef logic [1:0]                 joint_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic signed [VALUE_W-1:0]  value_t;
	typedef logic signed [XW-1:0]       wide_t;
	typedef logic [SPEED_W-1:0]         speed_t;
	typedef logic [TICK_W-1:0]          tick_t;

	localparam mode_t MODE_REPORT  = 2'd0;
	localparam mode_t MODE_COMMAND = 2'd1;
	localparam mode_t MODE_TICK    = 2'd2;

	localparam joint_t JOINT_YAW   = 2'd0;
	localparam joint_t JOINT_PITCH = 2'd3;

	localparam cfg_idx_t CFG_MAX_SPEED   = 3'd0;
	localparam cfg_idx_t CFG_YAW_UPPER   = 3'd1;
	localparam cfg_idx_t CFG_YAW_LOWER   = 3'd2;
	localparam cfg_idx_t CFG_PITCH_UPPER = 3'd3;
	localparam cfg_idx_t CFG_PITCH_LOWER = 3'd4;
	localparam cfg_idx_t CFG_RESEND_STEP = 3'd5;
	localparam cfg_idx_t CFG_IDLE_SPEED  = 3'd6;
	localparam cfg_idx_t CFG_TIMEOUT     = 3'd7;

	localparam speed_t RST_MAX_SPEED   = 23'd419430;
	localparam value_t RST_YAW_UPPER   = 24'sd3111252;
	localparam value_t RST_YAW_LOWER   = -24'sd3111252;
	localparam value_t RST_PITCH_UPPER = -24'sd183007;
	localparam value_t RST_PITCH_LOWER = -24'sd2196079;
	localparam speed_t RST_RESEND_STEP = 23'd20972;
	localparam speed_t RST_IDLE_SPEED  = 23'd105;
	localparam tick_t  RST_TIMEOUT     = 16'd250;

	// largest raw speed that still counts as no motion; only speeds above it count as motion
	localparam speed_t MOTION_EPS = 23'd1;

	typedef struct packed {
		mode_t  mode;
		value_t yaw_position;
		value_t yaw_velocity;
		value_t pitch_position;
		value_t pitch_velocity;
		value_t yaw_command;
		value_t pitch_command;
	} in_item_t;

	typedef struct packed {
		joint_t joint_id;
		value_t drive_velocity;
		logic   last_of_run;
	} out_item_t;

	typedef struct packed {
		speed_t max_speed;
		value_t yaw_upper_limit;
		value_t yaw_lower_limit;
		value_t pitch_upper_limit;
		value_t pitch_lower_limit;
		speed_t resend_step;
		speed_t idle_speed;
		tick_t  timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic   refuse_report;
		logic   cmd_active;
		logic   cmd_send;
		logic   stop_idle;
		value_t cmd_value;
	} axis_res_t;

	function automatic wide_t widen(input value_t v);
		widen = {v[VALUE_W-1], v};
	endfunction

	function automatic wide_t speed_to_wide(input speed_t s);
		speed_to_wide = {{(XW-SPEED_W){1'b0}}, s};
	endfunction

	function automatic logic [XW-1:0] mag_of(input wide_t v);
		mag_of = v[XW-1] ? XW'(-v) : XW'(v);
	endfunction

	// true when the velocity pushes the joint further into a limit
	function automatic logic refuses(input wide_t vel, input value_t pos,
			input value_t upper, input value_t lower);
		wide_t eps;
		eps = speed_to_wide(MOTION_EPS);
		refuses = (vel > eps && pos >= upper) || (vel < -eps && pos <= lower);
	endfunction

endpackage

`default_nettype wire

// File: rtl/joint_limit_velocity_guard.sv
// ----------------------------------------------------------------------------
// joint_limit_velocity_guard
// yaw and pitch joint guard: limit stops, command clamp and resend, tick timeout
// ----------------------------------------------------------------------------
// An item is taken into the input register and evaluated combinationally
// against the stored joint report, moving flag and tick counter; its zero,
// one or two results (yaw first) are written into a four-entry result queue
// once the queue has room for two, and the output is driven from the head of
// that queue. A new item is accepted every cycle as long as the queue has room
// for two results, so the sustained rate is one item per cycle, bounded by the
// output port's one result per cycle while out_ready is high when items yield
// two results.
`timescale 1ns / 1ps
`default_nettype none
`include "joint_limit_velocity_guard_assert.svh"

module joint_limit_velocity_guard (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire jlvg_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire                       out_ready,
	output jlvg_pkg::out_item_t       out_item,
	input  wire                       cfg_write,
	input  wire jlvg_pkg::cfg_idx_t   cfg_index,
	input  wire jlvg_pkg::value_t     cfg_data
);
	import jlvg_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      can_push2;

	logic      report_seen_q;
	logic      moving_q;
	value_t    yaw_pos_q;
	value_t    yaw_vel_q;
	value_t    pitch_pos_q;
	value_t    pitch_vel_q;
	tick_t     ticks_q;

	axis_res_t yaw_res;
	axis_res_t pitch_res;

	logic      yaw_emit;
	logic      pitch_emit;
	value_t    yaw_value;
	value_t    pitch_value;
	logic      tick_timeout;
	tick_t     ticks_next;
	logic [1:0] push_n;
	out_item_t yaw_entry;
	out_item_t pitch_entry;
	out_item_t push_item0;
	out_item_t push_item1;

	jlvg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	assign advance  = valid_s1 && can_push2;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	jlvg_axis u_yaw (
		.report_pos    (item_s1.yaw_position),
		.report_vel    (item_s1.yaw_velocity),
		.command       (item_s1.yaw_command),
		.stored_pos    (yaw_pos_q),
		.stored_vel    (yaw_vel_q),
		.upper_limit   (cfg.yaw_upper_limit),
		.lower_limit   (cfg.yaw_lower_limit),
		.max_speed     (cfg.max_speed),
		.resend_step   (cfg.resend_step),
		.idle_speed    (cfg.idle_speed),
		.active_thresh (cfg.idle_speed),
		.res           (yaw_res)
	);

	jlvg_axis u_pitch (
		.report_pos    (item_s1.pitch_position),
		.report_vel    (item_s1.pitch_velocity),
		.command       (item_s1.pitch_command),
		.stored_pos    (pitch_pos_q),
		.stored_vel    (pitch_vel_q),
		.upper_limit   (cfg.pitch_upper_limit),
		.lower_limit   (cfg.pitch_lower_limit),
		.max_speed     (cfg.max_speed),
		.resend_step   (cfg.resend_step),
		.idle_speed    (cfg.idle_speed),
		.active_thresh (MOTION_EPS),
		.res           (pitch_res)
	);

	assign ticks_next   = (ticks_q == '1) ? ticks_q : ticks_q + TICK_W'(1);
	assign tick_timeout = item_s1.mode == MODE_TICK && moving_q
		&& ticks_next >= cfg.timeout_ticks;

	always_comb begin
		yaw_emit    = 1'b0;
		pitch_emit  = 1'b0;
		yaw_value   = '0;
		pitch_value = '0;
		case (item_s1.mode)
			MODE_REPORT: begin
				yaw_emit   = moving_q && yaw_res.refuse_report;
				pitch_emit = moving_q && pitch_res.refuse_report;
			end
			MODE_COMMAND: begin
				if (report_seen_q) begin
					yaw_emit    = yaw_res.cmd_active ? yaw_res.cmd_send : yaw_res.stop_idle;
					pitch_emit  = pitch_res.cmd_active ? pitch_res.cmd_send
						: pitch_res.stop_idle;
					yaw_value   = yaw_res.cmd_active ? yaw_res.cmd_value : '0;
					pitch_value = pitch_res.cmd_active ? pitch_res.cmd_value : '0;
				end
			end
			MODE_TICK: begin
				yaw_emit   = tick_timeout;
				pitch_emit = tick_timeout;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		yaw_entry.joint_id         = JOINT_YAW;
		yaw_entry.drive_velocity   = yaw_value;
		yaw_entry.last_of_run      = !pitch_emit;
		pitch_entry.joint_id       = JOINT_PITCH;
		pitch_entry.drive_velocity = pitch_value;
		pitch_entry.last_of_run    = 1'b1;
		push_item0 = yaw_emit ? yaw_entry : pitch_entry;
		push_item1 = pitch_entry;
		push_n     = advance ? (2'(yaw_emit) + 2'(pitch_emit)) : 2'd0;
	end

	// joint state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_seen_q <= 1'b0;
			moving_q      <= 1'b0;
			yaw_pos_q     <= '0;
			yaw_vel_q     <= '0;
			pitch_pos_q   <= '0;
			pitch_vel_q   <= '0;
			ticks_q       <= '0;
		end else if (advance) begin
			case (item_s1.mode)
				MODE_REPORT: begin
					yaw_pos_q     <= item_s1.yaw_position;
					yaw_vel_q     <= item_s1.yaw_velocity;
					pitch_pos_q   <= item_s1.pitch_position;
					pitch_vel_q   <= item_s1.pitch_velocity;
					report_seen_q <= 1'b1;
				end
				MODE_COMMAND: begin
					if (report_seen_q) begin
						ticks_q  <= '0;
						moving_q <= yaw_res.cmd_active || pitch_res.cmd_active;
					end
				end
				MODE_TICK: begin
					ticks_q <= ticks_next;
					if (tick_timeout) begin
						moving_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	jlvg_result_fifo u_results (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_item0 (push_item0),
		.push_item1 (push_item1),
		.can_push2  (can_push2),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	`JLVG_ASSERT(a_moving_needs_report, moving_q |-> report_seen_q)
	`JLVG_ASSERT(a_cmd_before_report_silent,
		advance && item_s1.mode == MODE_COMMAND && !report_seen_q |-> push_n == 2'd0)
	`JLVG_ASSERT_NEXT(a_timeout_clears_moving, advance && tick_timeout, !moving_q)

endmodule

`default_nettype wire

// File: rtl/jlvg_cfg_regs.sv
// ----------------------------------------------------------------------------
// jlvg_cfg_regs
// configuration register file, written through the plain write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jlvg_cfg_regs (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_write,
	input  wire jlvg_pkg::cfg_idx_t  cfg_index,
	input  wire jlvg_pkg::value_t    cfg_data,
	output jlvg_pkg::cfg_t           cfg
);
	import jlvg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed         <= RST_MAX_SPEED;
			cfg_q.yaw_upper_limit   <= RST_YAW_UPPER;
			cfg_q.yaw_lower_limit   <= RST_YAW_LOWER;
			cfg_q.pitch_upper_limit <= RST_PITCH_UPPER;
			cfg_q.pitch_lower_limit <= RST_PITCH_LOWER;
			cfg_q.resend_step       <= RST_RESEND_STEP;
			cfg_q.idle_speed        <= RST_IDLE_SPEED;
			cfg_q.timeout_ticks     <= RST_TIMEOUT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MAX_SPEED:   cfg_q.max_speed         <= cfg_data[SPEED_W-1:0];
				CFG_YAW_UPPER:   cfg_q.yaw_upper_limit   <= cfg_data;
				CFG_YAW_LOWER:   cfg_q.yaw_lower_limit   <= cfg_data;
				CFG_PITCH_UPPER: cfg_q.pitch_upper_limit <= cfg_data;
				CFG_PITCH_LOWER: cfg_q.pitch_lower_limit <= cfg_data;
				CFG_RESEND_STEP: cfg_q.resend_step       <= cfg_data[SPEED_W-1:0];
				CFG_IDLE_SPEED:  cfg_q.idle_speed        <= cfg_data[SPEED_W-1:0];
				CFG_TIMEOUT:     cfg_q.timeout_ticks     <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/jlvg_axis.sv
// ----------------------------------------------------------------------------
// jlvg_axis
// per-joint decisions: limit refusal on a report, clamp and resend on a command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jlvg_axis (
	input  wire jlvg_pkg::value_t   report_pos,
	input  wire jlvg_pkg::value_t   report_vel,
	input  wire jlvg_pkg::value_t   command,
	input  wire jlvg_pkg::value_t   stored_pos,
	input  wire jlvg_pkg::value_t   stored_vel,
	input  wire jlvg_pkg::value_t   upper_limit,
	input  wire jlvg_pkg::value_t   lower_limit,
	input  wire jlvg_pkg::speed_t   max_speed,
	input  wire jlvg_pkg::speed_t   resend_step,
	input  wire jlvg_pkg::speed_t   idle_speed,
	input  wire jlvg_pkg::speed_t   active_thresh,
	output jlvg_pkg::axis_res_t     res
);
	import jlvg_pkg::*;

	wide_t cmd_x;
	wide_t max_x;
	wide_t clamped;
	wide_t delta;

	always_comb begin
		cmd_x = widen(command);
		max_x = speed_to_wide(max_speed);
		if (cmd_x > max_x) begin
			clamped = max_x;
		end else if (cmd_x < -max_x) begin
			clamped = -max_x;
		end else begin
			clamped = cmd_x;
		end
		delta = clamped - widen(stored_vel);

		res.refuse_report = refuses(widen(report_vel), report_pos, upper_limit, lower_limit);
		res.cmd_active    = (mag_of(clamped) > XW'(speed_to_wide(active_thresh)))
			&& !refuses(clamped, stored_pos, upper_limit, lower_limit);
		res.cmd_send      = mag_of(delta) > XW'(speed_to_wide(resend_step));
		// joint still turning while its command is idle or refused
		res.stop_idle     = mag_of(widen(stored_vel)) > XW'(speed_to_wide(idle_speed));
		res.cmd_value     = clamped[VALUE_W-1:0];
	end

endmodule

`default_nettype wire

// File: rtl/jlvg_result_fifo.sv
// ----------------------------------------------------------------------------
// jlvg_result_fifo
// small result queue, takes up to two results a cycle while it has room for two and issues one while out_ready is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "joint_limit_velocity_guard_assert.svh"

module jlvg_result_fifo (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire [1:0]                 push_n,
	input  wire jlvg_pkg::out_item_t  push_item0,
	input  wire jlvg_pkg::out_item_t  push_item1,
	output logic                      can_push2,
	output logic                      out_valid,
	input  wire                       out_ready,
	output jlvg_pkg::out_item_t       out_item
);
	import jlvg_pkg::*;

	out_item_t mem_q [RESULT_DEPTH];
	logic [RPTR_W-1:0] rd_ptr_q;
	logic [RPTR_W-1:0] wr_ptr_q;
	logic [RCNT_W-1:0] count_q;
	logic [RPTR_W-1:0] wr_ptr_p1;
	logic              pop;

	assign wr_ptr_p1 = wr_ptr_q + RPTR_W'(1);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign can_push2 = count_q <= RCNT_W'(RESULT_DEPTH - 2);
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_item0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RPTR_W'(1);
			end
			wr_ptr_q <= wr_ptr_q + RPTR_W'(push_n);
			count_q  <= count_q + RCNT_W'(push_n) - RCNT_W'(pop);
		end
	end

	`JLVG_ASSERT(a_count_bound, count_q <= RCNT_W'(RESULT_DEPTH))
	`JLVG_ASSERT(a_push_room, push_n != 2'd0 |-> can_push2)
	// a run's two results are queued together, so its tail is always present
	`JLVG_ASSERT(a_run_tail_queued, pop && !out_item.last_of_run |-> count_q >= RCNT_W'(2))

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// joint limit velocity guard testbench
// drives reports, commands and ticks through the valid/ready input, predicts
// the stop and resend commands of both joints and checks every result item in
// order, across several register settings including the extremes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import jlvg_pkg::*;

	localparam int     CLK_PERIOD    = 8;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     HOLD_CYCLES   = 80;
	localparam int     PHASE_ITEMS   = 200;
	localparam longint TICK_ALL_ONES = (longint'(1) << TICK_W) - 1;
	localparam mode_t  MODE_UNUSED   = 2'd3;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_write = 1'b0;
	cfg_idx_t  cfg_index = CFG_MAX_SPEED;
	value_t    cfg_data  = '0;

	joint_limit_velocity_guard dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// register copies
	longint max_rate   = longint'(RST_MAX_SPEED);
	longint yaw_hi     = longint'(RST_YAW_UPPER);
	longint yaw_lo     = longint'(RST_YAW_LOWER);
	longint pitch_hi   = longint'(RST_PITCH_UPPER);
	longint pitch_lo   = longint'(RST_PITCH_LOWER);
	longint resend_thr = longint'(RST_RESEND_STEP);
	longint idle_thr   = longint'(RST_IDLE_SPEED);
	longint stop_after = longint'(RST_TIMEOUT);

	// guard state
	bit     report_held    = 1'b0;
	bit     in_motion      = 1'b0;
	longint meas_yaw_pos   = 0;
	longint meas_yaw_vel   = 0;
	longint meas_pitch_pos = 0;
	longint meas_pitch_vel = 0;
	longint quiet_ticks    = 0;

	out_item_t step_out[$];
	out_item_t pending_drives[$];
	int        mismatches = 0;

	// typed results for the directed item on the bus, -1 means use the predictor
	int        fixed_n = -1;
	out_item_t fixed_a = '0;
	out_item_t fixed_b = '0;

	bit idle_on      = 1'b1;
	bit hold_outputs = 1'b0;

	typedef struct {
		in_item_t  item;
		int        n_fixed;
		out_item_t fixed_a;
		out_item_t fixed_b;
	} probe_t;

	probe_t probes[$];

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic longint mag64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit refused(longint vel, longint pos, longint hi, longint lo);
		longint eps;
		eps = longint'(MOTION_EPS);
		return (vel > eps && pos >= hi) || (vel < -eps && pos <= lo);
	endfunction

	function automatic longint clamp_rate(longint v);
		if (v > max_rate)
			return max_rate;
		if (v < -max_rate)
			return -max_rate;
		return v;
	endfunction

	function automatic out_item_t drive_word(joint_t j, longint v, logic last);
		out_item_t w;
		w.joint_id       = j;
		w.drive_velocity = value_t'(v);
		w.last_of_run    = last;
		return w;
	endfunction

	function automatic void push_drive(joint_t j, longint v);
		step_out.push_back(drive_word(j, v, 1'b0));
	endfunction

	function automatic void predict_drives(in_item_t it);
		longint yaw_cmd;
		longint pitch_cmd;
		bit     move;
		step_out.delete();
		case (it.mode)
			MODE_REPORT: begin
				meas_yaw_pos   = longint'(it.yaw_position);
				meas_yaw_vel   = longint'(it.yaw_velocity);
				meas_pitch_pos = longint'(it.pitch_position);
				meas_pitch_vel = longint'(it.pitch_velocity);
				report_held    = 1'b1;
				if (in_motion) begin
					if (refused(meas_yaw_vel, meas_yaw_pos, yaw_hi, yaw_lo))
						push_drive(JOINT_YAW, 0);
					if (refused(meas_pitch_vel, meas_pitch_pos, pitch_hi, pitch_lo))
						push_drive(JOINT_PITCH, 0);
				end
			end
			MODE_COMMAND: begin
				if (report_held) begin
					yaw_cmd     = clamp_rate(longint'(it.yaw_command));
					pitch_cmd   = clamp_rate(longint'(it.pitch_command));
					move        = 1'b0;
					quiet_ticks = 0;
					if (mag64(yaw_cmd) > idle_thr &&
							!refused(yaw_cmd, meas_yaw_pos, yaw_hi, yaw_lo)) begin
						if (mag64(yaw_cmd - meas_yaw_vel) > resend_thr)
							push_drive(JOINT_YAW, yaw_cmd);
						move = 1'b1;
					end else if (mag64(meas_yaw_vel) > idle_thr) begin
						push_drive(JOINT_YAW, 0);
					end
					// pitch uses the motion threshold, not idle_speed, for the command
					if (mag64(pitch_cmd) > longint'(MOTION_EPS) &&
							!refused(pitch_cmd, meas_pitch_pos, pitch_hi, pitch_lo)) begin
						if (mag64(pitch_cmd - meas_pitch_vel) > resend_thr)
							push_drive(JOINT_PITCH, pitch_cmd);
						move = 1'b1;
					end else if (mag64(meas_pitch_vel) > idle_thr) begin
						push_drive(JOINT_PITCH, 0);
					end
					in_motion = move;
				end
			end
			MODE_TICK: begin
				if (quiet_ticks < TICK_ALL_ONES)
					quiet_ticks++;
				if (in_motion && quiet_ticks >= stop_after) begin
					push_drive(JOINT_YAW, 0);
					push_drive(JOINT_PITCH, 0);
					in_motion = 1'b0;
				end
			end
			default: ;
		endcase
		if (step_out.size() != 0)
			step_out[step_out.size() - 1].last_of_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s) at %0t: want joint %0d vel %0d last %0b, got joint %0d vel %0d last %0b",
				what, $realtime, want.joint_id, want.drive_velocity, want.last_of_run,
				got.joint_id, got.drive_velocity, got.last_of_run);
	endfunction

	always @(posedge clk) begin : scoreboard
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_drives(in_item);
				if (fixed_n < 0) begin
					foreach (step_out[k])
						pending_drives.push_back(step_out[k]);
				end else begin
					if (fixed_n > 0)
						pending_drives.push_back(fixed_a);
					if (fixed_n > 1)
						pending_drives.push_back(fixed_b);
				end
			end
			if (out_valid && out_ready) begin
				if (pending_drives.size() == 0) begin
					note_mismatch("unexpected result", '0, out_item);
				end else begin
					want = pending_drives.pop_front();
					if (out_item.joint_id !== want.joint_id ||
							out_item.drive_velocity !== want.drive_velocity ||
							out_item.last_of_run !== want.last_of_run)
						note_mismatch("wrong field", want, out_item);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result side: random stalls and one long hold-off
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		forever begin
			@(negedge clk);
			if (hold_outputs) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_outputs = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 6);
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic in_item_t blank_item(mode_t m);
		in_item_t it;
		it.mode           = m;
		it.yaw_position   = value_t'($urandom);
		it.yaw_velocity   = value_t'($urandom);
		it.pitch_position = value_t'($urandom);
		it.pitch_velocity = value_t'($urandom);
		it.yaw_command    = value_t'($urandom);
		it.pitch_command  = value_t'($urandom);
		return it;
	endfunction

	function automatic in_item_t report_item(longint yp, longint yv, longint pp, longint pv);
		in_item_t it;
		it                = blank_item(MODE_REPORT);
		it.yaw_position   = value_t'(yp);
		it.yaw_velocity   = value_t'(yv);
		it.pitch_position = value_t'(pp);
		it.pitch_velocity = value_t'(pv);
		return it;
	endfunction

	function automatic in_item_t command_item(longint y, longint p);
		in_item_t it;
		it               = blank_item(MODE_COMMAND);
		it.yaw_command   = value_t'(y);
		it.pitch_command = value_t'(p);
		return it;
	endfunction

	function automatic longint jitter(longint c);
		return c + longint'($urandom_range(0, 6)) - 3;
	endfunction

	function automatic longint either_sign(longint v);
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic longint any_value();
		return longint'(value_t'($urandom));
	endfunction

	// positions cluster on the limits so that refusals happen often
	function automatic longint pick_position(longint hi, longint lo);
		case ($urandom_range(0, 4))
			0: return jitter(hi);
			1: return jitter(lo);
			2: return any_value();
			default: begin
				if (hi > lo)
					return lo + longint'($urandom_range(0, 32'(hi - lo)));
				return any_value();
			end
		endcase
	endfunction

	// rates cluster on the idle, clamp and resend thresholds
	function automatic longint pick_rate(longint meas);
		case ($urandom_range(0, 6))
			0: return any_value();
			1: return jitter(0);
			2: return either_sign(jitter(idle_thr));
			3: return either_sign(jitter(max_rate));
			4: return jitter(meas + either_sign(resend_thr));
			5: return jitter(meas);
			default: return either_sign(longint'($urandom_range(0, 600000)));
		endcase
	endfunction

	function automatic in_item_t random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 33)
			return report_item(pick_position(yaw_hi, yaw_lo), pick_rate(0),
				pick_position(pitch_hi, pitch_lo), pick_rate(0));
		if (pick < 70)
			return command_item(pick_rate(meas_yaw_vel), pick_rate(meas_pitch_vel));
		if (pick < 98)
			return blank_item(MODE_TICK);
		return blank_item(MODE_UNUSED);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(in_item_t it, int n = -1, out_item_t a = '0, out_item_t b = '0);
		fixed_n  = n;
		fixed_a  = a;
		fixed_b  = b;
		in_item  <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic random_items(int count);
		repeat (count) begin
			sender_gap();
			send_item(random_item());
		end
	endtask

	task automatic add_probe(in_item_t it, int n = -1, out_item_t a = '0, out_item_t b = '0);
		probe_t p;
		p.item    = it;
		p.n_fixed = n;
		p.fixed_a = a;
		p.fixed_b = b;
		probes.push_back(p);
	endtask

	task automatic run_probes();
		foreach (probes[k]) begin
			sender_gap();
			send_item(probes[k].item, probes[k].n_fixed, probes[k].fixed_a, probes[k].fixed_b);
		end
		probes.delete();
	endtask

	// input goes quiet until every result is out and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(cfg_idx_t idx, longint v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value_t'(v);
		@(negedge clk);
	endtask

	task automatic load_settings(longint ms, longint yh, longint yl, longint ph, longint pl,
			longint rs, longint idl, longint to);
		put_reg(CFG_MAX_SPEED, ms);
		put_reg(CFG_YAW_UPPER, yh);
		put_reg(CFG_YAW_LOWER, yl);
		put_reg(CFG_PITCH_UPPER, ph);
		put_reg(CFG_PITCH_LOWER, pl);
		put_reg(CFG_RESEND_STEP, rs);
		put_reg(CFG_IDLE_SPEED, idl);
		put_reg(CFG_TIMEOUT, to);
		cfg_write  <= 1'b0;
		max_rate   = longint'(speed_t'(ms));
		yaw_hi     = longint'(value_t'(yh));
		yaw_lo     = longint'(value_t'(yl));
		pitch_hi   = longint'(value_t'(ph));
		pitch_lo   = longint'(value_t'(pl));
		resend_thr = longint'(speed_t'(rs));
		idle_thr   = longint'(speed_t'(idl));
		stop_after = longint'(tick_t'(to));
	endtask

	task automatic load_reset_settings(longint to);
		load_settings(longint'(RST_MAX_SPEED), longint'(RST_YAW_UPPER),
			longint'(RST_YAW_LOWER), longint'(RST_PITCH_UPPER),
			longint'(RST_PITCH_LOWER), longint'(RST_RESEND_STEP),
			longint'(RST_IDLE_SPEED), to);
	endtask

	task automatic rand_settings();
		longint ylo;
		longint plo;
		ylo = -longint'($urandom_range(0, 4000000));
		plo = -longint'($urandom_range(0, 4000000));
		load_settings($urandom_range(0, 1000000), ylo + $urandom_range(0, 5000000), ylo,
			plo + $urandom_range(0, 5000000), plo, $urandom_range(0, 60000),
			$urandom_range(0, 3000), $urandom_range(1, 12));
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings
		add_probe(command_item(100000, 100000), 0);              // command before any report
		add_probe(blank_item(MODE_UNUSED), 0);
		add_probe(blank_item(MODE_TICK), 0);                     // tick while still
		add_probe(report_item(0, 0, -1000000, 0), 0);
		add_probe(command_item(8388607, 0), 1, drive_word(JOINT_YAW, 419430, 1'b1));
		add_probe(command_item(-8388608, -8388608), 2,
			drive_word(JOINT_YAW, -419430, 1'b0), drive_word(JOINT_PITCH, -419430, 1'b1));
		// both joints driven into their limits while moving
		add_probe(report_item(8388607, 8388607, -8388608, -8388608), 2,
			drive_word(JOINT_YAW, 0, 1'b0), drive_word(JOINT_PITCH, 0, 1'b1));
		// yaw speed on the motion threshold, pitch exactly at its upper limit
		add_probe(report_item(-8388608, -1, -183007, 2), 1, drive_word(JOINT_PITCH, 0, 1'b1));
		add_probe(command_item(105, 1), 0);                      // both commands idle
		add_probe(report_item(0, 20000, -1000000, -300), 0);
		add_probe(command_item(106, 2));
		add_probe(command_item(40973, -21273));
		add_probe(report_item(3111251, 500, -2196079, -500));
		add_probe(command_item(0, 0), 2,
			drive_word(JOINT_YAW, 0, 1'b0), drive_word(JOINT_PITCH, 0, 1'b1));
		add_probe(command_item(300000, 300000));
		run_probes();
		drain();

		// shortest timeout
		load_reset_settings(1);
		add_probe(report_item(0, 0, -1000000, 0), 0);
		add_probe(command_item(200000, 0), 1, drive_word(JOINT_YAW, 200000, 1'b1));
		add_probe(blank_item(MODE_TICK), 2,
			drive_word(JOINT_YAW, 0, 1'b0), drive_word(JOINT_PITCH, 0, 1'b1));
		add_probe(blank_item(MODE_TICK), 0);
		add_probe(command_item(0, -419430));
		add_probe(report_item(0, 0, -2196079, -419430));
		add_probe(blank_item(MODE_TICK));
		run_probes();
		drain();

		// back to reset settings, then a full timeout run of ticks
		load_reset_settings(longint'(RST_TIMEOUT));
		random_items(PHASE_ITEMS);
		send_item(report_item(0, 0, -1000000, 0));
		send_item(command_item(8388607, 0));
		repeat (stop_after + 1)
			send_item(blank_item(MODE_TICK));
		drain();

		// widest limits, zero thresholds: nearly every command sends both axes
		load_settings(8388607, 8388607, -8388608, 8388607, -8388608, 0, 0, 1);
		random_items(PHASE_ITEMS / 2);
		hold_outputs = 1'b1;
		repeat (40)
			send_item($urandom_range(0, 3) == 0 ? blank_item(MODE_TICK) :
				command_item(any_value(), any_value()));
		random_items(PHASE_ITEMS / 2);
		drain();

		// no speed allowed, every position refused, largest thresholds
		load_settings(0, -8388608, 8388607, -8388608, 8388607, 8388607, 8388607, 65535);
		random_items(PHASE_ITEMS);
		drain();

		repeat (3) begin
			rand_settings();
			random_items(PHASE_ITEMS);
			drain();
		end

		rand_settings();
		idle_on = 1'b0;
		random_items(PHASE_ITEMS);
		drain();

		if (mismatches == 0 && pending_drives.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
